>>> design/assert_macros.svh
// Assertion macros shared by the sorted table counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is low.
`define STCV_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("stcv: assertion failed");

// Checks that the consequent holds in the same cycle as the antecedent.
`define STCV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stcv: implication failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define STCV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stcv: next-cycle implication failed");

`endif

>>> design/stcv_pkg.sv
// Shared types and constants of the sorted table counter.
package stcv_pkg;

   // Default table capacity.
   localparam int TABLE_DEPTH_DEF = 1024;

   // Depth of the command queue between front and back; a power of two.
   localparam int QUEUE_DEPTH = 4;

   // Width of a table value.
   localparam int VALUE_W = 32;

   // Command codes on the request channel.
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   // Operations that the back end carries out.
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   // One classified command as it travels through the queue.
   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  operand;
   } cmd_item_type;

endpackage

>>> design/stcv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stcv_ram
   #(
      parameter int WIDTH = 32,
      parameter int DEPTH = 1024,
      localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
   )
   (
      input  logic              clock,
      input  logic              wr_en,
      input  logic [ADDR_W-1:0] wr_addr,
      input  logic [WIDTH-1:0]  wr_data,
      input  logic              rd_en,
      input  logic [ADDR_W-1:0] rd_addr,
      output logic [WIDTH-1:0]  rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/stcv_front.sv
// Front end: accepts request transactions and classifies them into operations.
module stcv_front
   import stcv_pkg::*;
   (
      input  logic                       req_valid,
      output logic                       req_stall,
      input  logic [1:0]                 req_cmd,
      input  logic signed [VALUE_W-1:0]  req_element,
      input  logic signed [VALUE_W-1:0]  req_target,
      input  logic                       q_full,
      output logic                       q_push,
      output cmd_item_type               q_item
   );

   logic known_cmd;

   // The request channel stalls only while the queue has no room.
   assign req_stall = q_full;

   // Map the command code to an operation and pick the operand it uses.
   always_comb begin
      known_cmd      = 1'b1;
      q_item.op      = OP_CLEAR;
      q_item.operand = req_element;
      unique case (req_cmd)
         CMD_CLEAR: begin
            q_item.op = OP_CLEAR;
         end
         CMD_APPEND: begin
            q_item.op      = OP_APPEND;
            q_item.operand = req_element;
         end
         CMD_QUERY: begin
            q_item.op      = OP_QUERY;
            q_item.operand = req_target;
         end
         default: begin
            // The unused code is accepted and dropped.
            known_cmd = 1'b0;
         end
      endcase
   end

   // Only meaningful commands enter the queue.
   assign q_push = req_valid && !q_full && known_cmd;

endmodule

>>> design/stcv_queue.sv
// Short FIFO of classified commands between the front and back ends.
`include "assert_macros.svh"

module stcv_queue
   import stcv_pkg::*;
   (
      input  logic         clock,
      input  logic         reset,
      input  logic         push,
      input  cmd_item_type push_item,
      output logic         full,
      input  logic         pop,
      output logic         head_valid,
      output cmd_item_type head_item
   );

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   cmd_item_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign full       = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update; pointers wrap at the power-of-two depth.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `STCV_ASSERT(a_count_in_range, clock, reset, count_ff <= (PTR_W+1)'(QUEUE_DEPTH))
   `STCV_ASSERT_IMP(a_no_push_when_full, clock, reset, push, !full)
   `STCV_ASSERT_IMP(a_no_pop_when_empty, clock, reset, pop, head_valid)
   `STCV_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

>>> design/stcv_back.sv
// Back end: owns the table and runs clear, append and the two bound searches.
`include "assert_macros.svh"

module stcv_back
   import stcv_pkg::*;
   #(
      parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
      localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
   )
   (
      input  logic             clock,
      input  logic             reset,
      input  logic             q_valid,
      input  cmd_item_type     q_item,
      output logic             q_pop,
      output logic             rsp_valid,
      input  logic             rsp_stall,
      output logic [CNT_W-1:0] rsp_match_count,
      output logic             rsp_overflowed
   );

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_UPPER = 4'b0010,
      S_LOWER = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       ovf_ff, ovf_in;
   logic [CNT_W-1:0]           lo_ff, lo_in;
   logic [CNT_W-1:0]           hi_ff, hi_in;
   logic [CNT_W-1:0]           mid_ff, mid_in;
   logic [CNT_W-1:0]           upper_ff, upper_in;
   logic signed [VALUE_W-1:0]  key_ff, key_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]           rsp_count_ff, rsp_count_in;
   logic                       rsp_ovf_ff, rsp_ovf_in;

   logic                       ram_we;
   logic                       ram_re;
   logic [ADDR_W-1:0]          ram_raddr;
   logic [VALUE_W-1:0]         ram_rdata;

   logic                       go_right;
   logic [CNT_W-1:0]           probe_lo;
   logic [CNT_W-1:0]           probe_hi;
   logic [CNT_W:0]             probe_sum;
   logic [CNT_W-1:0]           probe_mid;
   logic                       probe_more;
   logic [CNT_W-1:0]           init_mid;

   // Table storage; entries are written in order and read by the searches.
   stcv_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (q_item.operand),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // One probe: compare the entry read at mid and narrow the interval.
   // The upper bound search moves right on equal entries, the lower does not.
   always_comb begin
      if (state_ff == S_UPPER) begin
         go_right = ($signed(ram_rdata) <= key_ff);
      end else begin
         go_right = ($signed(ram_rdata) < key_ff);
      end
      probe_lo   = go_right ? mid_ff + 1'b1 : lo_ff;
      probe_hi   = go_right ? hi_ff : mid_ff;
      probe_sum  = {1'b0, probe_lo} + {1'b0, probe_hi};
      probe_mid  = probe_sum[CNT_W:1];
      probe_more = (probe_lo < probe_hi);
      init_mid   = count_ff >> 1;
   end

   // Sequencer for one operation at a time.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      upper_in     = upper_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_item.op)
                  OP_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  OP_APPEND: begin
                     if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     key_in   = q_item.operand;
                     lo_in    = '0;
                     hi_in    = count_ff;
                     mid_in   = init_mid;
                     upper_in = '0;
                     if (count_ff != '0) begin
                        ram_re    = 1'b1;
                        ram_raddr = init_mid[ADDR_W-1:0];
                        state_in  = S_UPPER;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_UPPER: begin
            lo_in  = probe_lo;
            hi_in  = probe_hi;
            mid_in = probe_mid;
            if (probe_more) begin
               ram_re    = 1'b1;
               ram_raddr = probe_mid[ADDR_W-1:0];
            end else begin
               // Upper bound found; start the lower bound search at once.
               upper_in  = probe_lo;
               lo_in     = '0;
               hi_in     = count_ff;
               mid_in    = init_mid;
               ram_re    = 1'b1;
               ram_raddr = init_mid[ADDR_W-1:0];
               state_in  = S_LOWER;
            end
         end

         S_LOWER: begin
            lo_in  = probe_lo;
            hi_in  = probe_hi;
            mid_in = probe_mid;
            if (probe_more) begin
               ram_re    = 1'b1;
               ram_raddr = probe_mid[ADDR_W-1:0];
            end else begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // Hand the count over once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = (upper_ff > lo_ff) ? upper_ff - lo_ff : '0;
               rsp_ovf_in   = ovf_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Search and result payload registers.
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      upper_ff     <= upper_in;
      key_ff       <= key_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_count = rsp_count_ff;
   assign rsp_overflowed  = rsp_ovf_ff;

   `STCV_ASSERT(a_count_in_range, clock, reset, count_ff <= CNT_W'(TABLE_DEPTH))
   `STCV_ASSERT_IMP(a_search_interval, clock, reset, state_ff == S_UPPER || state_ff == S_LOWER, lo_ff < hi_ff && hi_ff <= count_ff && mid_ff < hi_ff)
   `STCV_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_DONE)
   `STCV_ASSERT_IMP(a_pop_only_idle, clock, reset, q_pop, state_ff == S_IDLE && q_valid)

endmodule

>>> design/sorted_table_count_of_value.sv
// Top level of the sorted table counter: front end, command queue and back end.
//
// Usage: software fills a table of signed 32-bit values in non-decreasing order
// and asks how often a value occurs. Each request transaction carries req_cmd
// (clear, append req_element, or query req_target); code 3 is accepted and
// ignored. Only a query produces a response transaction, carrying
// rsp_match_count and the sticky rsp_overflowed flag (set when an append met a
// full table, cleared by a clear command).
// A four-entry queue separates acceptance from execution, so requests keep
// being accepted while a query runs, until the queue fills.
// A clear or append is done by the back end in its idle state. A query runs
// the upper and then the lower bound search and hands the count over from the
// done state; the probe counts of the two searches are each at most
// clog2(entries + 1), and one probe per cycle is set by the single read port
// of the table RAM. Queued work ahead of a query delays its response.
// Reset empties the table, clears the flag, the queue and any pending response.
// While rsp_stall is high a finished response holds in the output register and
// a following query waits once done, but the front end keeps filling the queue.
module sorted_table_count_of_value
   import stcv_pkg::*;
   #(
      parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
      localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
   )
   (
      input  logic                       clock,
      input  logic                       reset,
      input  logic                       req_valid,
      output logic                       req_stall,
      input  logic [1:0]                 req_cmd,
      input  logic signed [VALUE_W-1:0]  req_element,
      input  logic signed [VALUE_W-1:0]  req_target,
      output logic                       rsp_valid,
      input  logic                       rsp_stall,
      output logic [CNT_W-1:0]           rsp_match_count,
      output logic                       rsp_overflowed
   );

   logic         q_full;
   logic         q_push;
   cmd_item_type q_push_item;
   logic         q_pop;
   logic         q_head_valid;
   cmd_item_type q_head_item;

   // Request decode.
   stcv_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_element (req_element),
      .req_target  (req_target),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (q_push_item)
   );

   // Command queue.
   stcv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head_item)
   );

   // Table and search engine.
   stcv_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_head_valid),
      .q_item          (q_head_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_match_count (rsp_match_count),
      .rsp_overflowed  (rsp_overflowed)
   );

endmodule
